// ----- design/wsfd_pkg.sv -----
// Shared types and constants for the WebSocket frame decoder.
package wsfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned OPCODE_W = 4;
    localparam int unsigned LEN_W    = 64;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned USER_W   = 7;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    localparam logic [CNT_W-1:0] LEN16_BYTES = 4'd2;
    localparam logic [CNT_W-1:0] LEN64_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0   = 3'd0,
        PH_HDR1   = 3'd1,
        PH_EXTLEN = 3'd2,
        PH_KEY    = 3'd3,
        PH_DATA   = 3'd4
    } phase_t;

    // one result item as it leaves the block
    typedef struct packed {
        logic                payload_byte_valid;
        logic [BYTE_W-1:0]   payload_byte;
        logic                byte_valid;
        logic                frame_end;
        logic                final_fragment;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                was_masked;
    } result_t;

endpackage

// ----- design/websocket_frame_decoder.sv -----
// WebSocket frame decoder: header parse, length count and payload unmasking.
// Latency: a payload byte or an empty-frame marker appears on m_ the cycle after its
// input item is accepted. Throughput: one input item per cycle; s_tready drops only
// while a held result waits on m_tready. Header, length and key bytes give no result
// but for a zero-length frame's marker. The 64-bit remaining-length decrement and
// zero test set the per-item path. Reset (aresetn low, synchronous) clears the
// parser to expect a first header byte and empties the result register.
module websocket_frame_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic       m_tlast,   // frame_end
    output logic [wsfd_pkg::USER_W-1:0] m_tuser
    // m_tuser: [0] byte_valid, [1] final_fragment, [5:2] frame_opcode, [6] was_masked
);

    wsfd_pkg::phase_t                  phase_reg, phase_next;
    logic                              fin_reg, fin_next;
    logic [wsfd_pkg::OPCODE_W-1:0]     opcode_reg, opcode_next;
    logic                              mask_reg, mask_next;
    logic [wsfd_pkg::LEN_W-1:0]        rem_reg, rem_next;
    logic [wsfd_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [wsfd_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [1:0]                        kidx_reg, kidx_next;

    logic                              out_valid_reg, out_valid_next;
    logic [wsfd_pkg::BYTE_W-1:0]       out_byte_reg;
    logic                              out_bvalid_reg, out_last_reg, out_fin_reg, out_mask_reg;
    logic [wsfd_pkg::OPCODE_W-1:0]     out_opcode_reg;

    logic                              s_fire;
    logic                              emit;
    logic                              res_bvalid, res_last;
    logic [wsfd_pkg::BYTE_W-1:0]       res_byte;
    logic [6:0]                        len7;
    logic [wsfd_pkg::KEY_W-1:0]        key_shifted;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign len7     = s_tdata[6:0];
    // key byte 0 sits in the top bits
    assign key_shifted = key_reg >> {~kidx_reg, 3'b000};

    always_comb begin
        phase_next  = phase_reg;
        fin_next    = fin_reg;
        opcode_next = opcode_reg;
        mask_next   = mask_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        emit        = 1'b0;
        res_byte    = '0;
        res_bvalid  = 1'b0;
        res_last    = 1'b0;
        if (s_fire) begin
            case (phase_reg)
                wsfd_pkg::PH_HDR1: begin
                    mask_next = s_tdata[7];
                    key_next  = '0;
                    kidx_next = '0;
                    rem_next  = '0;
                    if (len7 == wsfd_pkg::LEN16_CODE) begin
                        cnt_next   = wsfd_pkg::LEN16_BYTES;
                        phase_next = wsfd_pkg::PH_EXTLEN;
                    end else if (len7 == wsfd_pkg::LEN64_CODE) begin
                        cnt_next   = wsfd_pkg::LEN64_BYTES;
                        phase_next = wsfd_pkg::PH_EXTLEN;
                    end else begin
                        rem_next = {{(wsfd_pkg::LEN_W-7){1'b0}}, len7};
                        if (s_tdata[7]) begin
                            cnt_next   = wsfd_pkg::KEY_BYTES;
                            phase_next = wsfd_pkg::PH_KEY;
                        end else if (len7 == 7'd0) begin
                            emit       = 1'b1;
                            res_last   = 1'b1;
                            phase_next = wsfd_pkg::PH_HDR0;
                        end else begin
                            phase_next = wsfd_pkg::PH_DATA;
                        end
                    end
                end
                wsfd_pkg::PH_EXTLEN: begin
                    rem_next = {rem_reg[wsfd_pkg::LEN_W-9:0], s_tdata};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_next == '0) begin
                        if (mask_reg) begin
                            cnt_next   = wsfd_pkg::KEY_BYTES;
                            phase_next = wsfd_pkg::PH_KEY;
                        end else begin
                            kidx_next = '0;
                            if (rem_next == '0) begin
                                emit       = 1'b1;
                                res_last   = 1'b1;
                                phase_next = wsfd_pkg::PH_HDR0;
                            end else begin
                                phase_next = wsfd_pkg::PH_DATA;
                            end
                        end
                    end
                end
                wsfd_pkg::PH_KEY: begin
                    key_next = {key_reg[wsfd_pkg::KEY_W-9:0], s_tdata};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_next == '0) begin
                        kidx_next = '0;
                        if (rem_reg == '0) begin
                            emit       = 1'b1;
                            res_last   = 1'b1;
                            phase_next = wsfd_pkg::PH_HDR0;
                        end else begin
                            phase_next = wsfd_pkg::PH_DATA;
                        end
                    end
                end
                wsfd_pkg::PH_DATA: begin
                    kidx_next  = kidx_reg + 2'd1;
                    rem_next   = rem_reg - 64'd1;
                    emit       = 1'b1;
                    res_bvalid = 1'b1;
                    res_byte   = s_tdata ^ key_shifted[7:0];
                    if (rem_next == '0) begin
                        res_last   = 1'b1;
                        phase_next = wsfd_pkg::PH_HDR0;
                    end
                end
                default: begin
                    fin_next    = s_tdata[7];
                    opcode_next = s_tdata[3:0];
                    phase_next  = wsfd_pkg::PH_HDR1;
                end
            endcase
        end
    end

    // hold the result until taken; refill in the same cycle it drains
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_tready) begin
            out_valid_next = s_fire && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= wsfd_pkg::PH_HDR0;
            fin_reg       <= 1'b0;
            opcode_reg    <= '0;
            mask_reg      <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            key_reg       <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            fin_reg       <= fin_next;
            opcode_reg    <= opcode_next;
            mask_reg      <= mask_next;
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            key_reg       <= key_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && emit) begin
            out_byte_reg   <= res_byte;
            out_bvalid_reg <= res_bvalid;
            out_last_reg   <= res_last;
            out_fin_reg    <= fin_next;
            out_opcode_reg <= opcode_next;
            out_mask_reg   <= mask_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_mask_reg, out_opcode_reg, out_fin_reg, out_bvalid_reg};

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result register not empty after reset");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result appeared without an accepted item");

    a_marker_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'd0))
        else $error("empty-frame marker malformed");

    a_frame_end_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && emit && res_last) |=> phase_reg == wsfd_pkg::PH_HDR0)
        else $error("parser not back at header after frame end");

    a_data_needs_length: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == wsfd_pkg::PH_DATA |-> rem_reg != '0)
        else $error("payload phase with nothing remaining");
`endif

endmodule
